@@ sv/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none
package spq_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_PEEK = 2'd0;
   localparam kind_type KIND_PUSH = 2'd1;
   localparam kind_type KIND_POP  = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ sv/spq_cell.sv @@
// One slot of the sorted queue chain: holds an entry and trades with its neighbors.
// Depends on spq_pkg for the control struct.
`default_nettype none
module spq_cell #(
   parameter int PRIO_BITS    = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire                            clock,
   input  spq_pkg::cell_ctrl_type         ctrl,
   input  wire                            occupied,
   input  wire signed [PRIO_BITS-1:0]     new_prio,
   input  wire        [PAYLOAD_BITS-1:0]  new_payload,
   input  wire                            left_shift,
   input  wire signed [PRIO_BITS-1:0]     left_prio,
   input  wire        [PAYLOAD_BITS-1:0]  left_payload,
   input  wire signed [PRIO_BITS-1:0]     right_prio,
   input  wire        [PAYLOAD_BITS-1:0]  right_payload,
   output logic                           shift,
   output logic signed [PRIO_BITS-1:0]    prio,
   output logic       [PAYLOAD_BITS-1:0]  payload,
   output logic signed [PRIO_BITS-1:0]    prio_next,
   output logic       [PAYLOAD_BITS-1:0]  payload_next
);
   import spq_pkg::*;

   logic signed [PRIO_BITS-1:0]    prio_ff;
   logic        [PAYLOAD_BITS-1:0] payload_ff;
   logic signed [PRIO_BITS-1:0]    prio_in;
   logic        [PAYLOAD_BITS-1:0] payload_in;

   // this slot and all behind it move back on a push
   assign shift = !occupied || (prio_ff < new_prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctrl.push && shift) begin
         if (left_shift) begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end else begin
            prio_in    = new_prio;
            payload_in = new_payload;
         end
      end else if (ctrl.pop) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio         = prio_ff;
   assign payload      = payload_ff;
   assign prio_next    = prio_in;
   assign payload_next = payload_in;

endmodule
`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue built as a chain of spq_cell slots, front at slot 0.
// The response is registered and appears in the cycle after the request is accepted.
// One request per cycle unless a held response is stalled; slots update in parallel.
// Reset clears the entry count and the response valid flag; slot contents stay undefined.
// Depends on spq_pkg and spq_cell.
`default_nettype none
module sorted_priority_queue #(
   parameter int DEPTH        = 16,
   parameter int PRIO_BITS    = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   // priority_req, payload
   input  wire  [((PRIO_BITS+PAYLOAD_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  spq_pkg::kind_type    req_tuser,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // accepted, is_empty, entry_count, front_priority, front_payload
   output logic [((2+$clog2(DEPTH+1)+PRIO_BITS+PAYLOAD_BITS+7)/8)*8-1:0] rsp_tdata
);
   import spq_pkg::*;

   localparam int CW       = $clog2(DEPTH + 1);
   localparam int RSP_BITS = 2 + CW + PRIO_BITS + PAYLOAD_BITS;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam logic [PRIO_BITS-1:0] EMPTY_PRIO =
      {1'b1, {(PRIO_BITS-2){1'b0}}, 1'b1};

   logic signed [PRIO_BITS-1:0]    new_prio;
   logic        [PAYLOAD_BITS-1:0] new_payload;
   logic                           req_fire;
   logic                           full;
   logic                           push_ok;
   cell_ctrl_type                  ctrl;

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                           shift_v [DEPTH];
   logic signed [PRIO_BITS-1:0]    prio_v [DEPTH];
   logic        [PAYLOAD_BITS-1:0] payload_v [DEPTH];
   logic signed [PRIO_BITS-1:0]    prio_nx [DEPTH];
   logic        [PAYLOAD_BITS-1:0] payload_nx [DEPTH];

   assign new_prio    = req_tdata[PRIO_BITS-1:0];
   assign new_payload = req_tdata[PRIO_BITS+PAYLOAD_BITS-1:PRIO_BITS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));
   assign push_ok    = req_fire && (req_tuser == KIND_PUSH) && !full;

   always_comb begin
      ctrl.push = push_ok;
      ctrl.pop  = req_fire && (req_tuser == KIND_POP) && (count_ff != '0);
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                           occ;
         logic                           l_shift;
         logic signed [PRIO_BITS-1:0]    l_prio, r_prio;
         logic        [PAYLOAD_BITS-1:0] l_payload, r_payload;

         assign occ = (count_ff > CW'(i));

         if (i == 0) begin : g_head
            assign l_shift   = 1'b0;
            assign l_prio    = new_prio;
            assign l_payload = new_payload;
         end else begin : g_body
            assign l_shift   = shift_v[i-1];
            assign l_prio    = prio_v[i-1];
            assign l_payload = payload_v[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign r_prio    = prio_v[i];
            assign r_payload = payload_v[i];
         end else begin : g_mid
            assign r_prio    = prio_v[i+1];
            assign r_payload = payload_v[i+1];
         end

         spq_cell #(
            .PRIO_BITS    (PRIO_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
         ) u_cell (
            .clock         (clock),
            .ctrl          (ctrl),
            .occupied      (occ),
            .new_prio      (new_prio),
            .new_payload   (new_payload),
            .left_shift    (l_shift),
            .left_prio     (l_prio),
            .left_payload  (l_payload),
            .right_prio    (r_prio),
            .right_payload (r_payload),
            .shift         (shift_v[i]),
            .prio          (prio_v[i]),
            .payload       (payload_v[i]),
            .prio_next     (prio_nx[i]),
            .payload_next  (payload_nx[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in[0]      = !((req_tuser == KIND_PUSH) && full);
         rsp_data_in[1]      = (count_in == '0);
         rsp_data_in[CW+1:2] = count_in;
         if (count_in == '0) begin
            rsp_data_in[CW+1+PRIO_BITS:CW+2]                       = EMPTY_PRIO;
            rsp_data_in[RSP_BITS-1:CW+2+PRIO_BITS]                 = '0;
         end else begin
            rsp_data_in[CW+1+PRIO_BITS:CW+2]                       = prio_nx[0];
            rsp_data_in[RSP_BITS-1:CW+2+PRIO_BITS]                 = payload_nx[0];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
`default_nettype wire

@@ tb/sv/sorted_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed and random push/pop/peek/spare-kind requests,
// each response checked field by field against a cycle-free model of the sorted queue.
// Depends on spq_pkg and sorted_priority_queue.
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int PRIO_BITS    = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int REQ_W        = ((PRIO_BITS + PAYLOAD_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((2 + $clog2(DEPTH + 1) + PRIO_BITS + PAYLOAD_BITS + 7) / 8) * 8;
   localparam int RANDOM_REQUESTS = 1800;
   localparam int QUIET_TAIL      = 300;

   localparam kind_type KIND_SPARE = 2'd3;
   localparam logic signed [PRIO_BITS-1:0] EMPTY_FRONT_PRIO = -16'sd32767;

   typedef struct {
      kind_type                      kind;
      logic signed [PRIO_BITS-1:0]   prio;
      logic [PAYLOAD_BITS-1:0]       tag;
   } queue_request_type;

   typedef struct {
      logic                          accepted;
      logic                          is_empty;
      logic [4:0]                    count;
      logic signed [PRIO_BITS-1:0]   front_prio;
      logic [PAYLOAD_BITS-1:0]       front_tag;
   } queue_status_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;  // priority_req, payload
   kind_type         req_tuser  = KIND_PEEK;  // kind
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;  // accepted, is_empty, entry_count, front_priority, front_payload

   queue_request_type pending_requests[$];
   queue_status_type  expected_status[$];

   logic signed [PRIO_BITS-1:0] queue_prio [DEPTH];
   logic [PAYLOAD_BITS-1:0]     queue_tag  [DEPTH];
   int queue_fill        = 0;
   int accepted_requests = 0;
   int checked_responses = 0;
   int total_requests    = 0;
   int error_count       = 0;
   int send_gap          = 0;
   int stall_left        = 0;

   sorted_priority_queue #(
      .DEPTH       (DEPTH),
      .PRIO_BITS   (PRIO_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic queue_status_type apply_request(input kind_type kind,
                                                   input logic signed [PRIO_BITS-1:0] prio,
                                                   input logic [PAYLOAD_BITS-1:0] tag);
      queue_status_type st;
      int pos;
      st.accepted = 1'b1;
      if (kind == KIND_PUSH) begin
         if (queue_fill >= DEPTH) begin
            st.accepted = 1'b0;
         end else begin
            pos = 0;
            while (pos < queue_fill && !(queue_prio[pos] < prio)) pos++;
            for (int k = queue_fill; k > pos; k--) begin
               queue_prio[k] = queue_prio[k-1];
               queue_tag[k]  = queue_tag[k-1];
            end
            queue_prio[pos] = prio;
            queue_tag[pos]  = tag;
            queue_fill++;
         end
      end else if (kind == KIND_POP && queue_fill > 0) begin
         for (int k = 1; k < queue_fill; k++) begin
            queue_prio[k-1] = queue_prio[k];
            queue_tag[k-1]  = queue_tag[k];
         end
         queue_fill--;
      end
      st.is_empty = (queue_fill == 0);
      st.count    = 5'(queue_fill);
      if (queue_fill == 0) begin
         st.front_prio = EMPTY_FRONT_PRIO;
         st.front_tag  = '0;
      end else begin
         st.front_prio = queue_prio[0];
         st.front_tag  = queue_tag[0];
      end
      return st;
   endfunction

   function automatic int idle_percent();
      if (accepted_requests >= total_requests - QUIET_TAIL) return 0;
      case ((accepted_requests / 150) % 4)
         0: return 20;
         1: return 0;
         2: return 45;
         default: return 8;
      endcase
   endfunction

   function automatic logic signed [PRIO_BITS-1:0] random_prio();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return PRIO_BITS'($urandom_range(0, 6) - 3);
      if (roll < 6) return PRIO_BITS'($urandom);
      if (roll == 6) begin
         case ($urandom_range(0, 4))
            0: return 16'sd32767;
            1: return -16'sd32768;
            2: return EMPTY_FRONT_PRIO;
            3: return 16'sd0;
            default: return -16'sd1;
         endcase
      end
      return PRIO_BITS'($urandom_range(0, 200) - 100);
   endfunction

   function automatic logic [PAYLOAD_BITS-1:0] random_tag();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   task automatic add_request(input kind_type kind, input logic signed [PRIO_BITS-1:0] prio,
                              input logic [PAYLOAD_BITS-1:0] tag);
      queue_request_type r;
      r.kind = kind;
      r.prio = prio;
      r.tag  = tag;
      pending_requests.push_back(r);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      queue_request_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_percent()) begin
            send_gap   <= $urandom_range(0, 18);
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_req   = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.kind;
            req_tdata  <= {next_req.tag, next_req.prio};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and response stalls
   always @(posedge clock) begin
      queue_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("response with no request outstanding, data %h",
                                         rsp_tdata));
            end else begin
               want = expected_status.pop_front();
               checked_responses <= checked_responses + 1;
               if (rsp_tdata[0] !== want.accepted)
                  report_mismatch($sformatf("accepted %b, want %b", rsp_tdata[0], want.accepted));
               if (rsp_tdata[1] !== want.is_empty)
                  report_mismatch($sformatf("is_empty %b, want %b", rsp_tdata[1], want.is_empty));
               if (rsp_tdata[6:2] !== want.count)
                  report_mismatch($sformatf("entry_count %0d, want %0d", rsp_tdata[6:2],
                                            want.count));
               if (rsp_tdata[22:7] !== want.front_prio)
                  report_mismatch($sformatf("front_priority %0d, want %0d",
                                            $signed(rsp_tdata[22:7]), want.front_prio));
               if (rsp_tdata[54:23] !== want.front_tag)
                  report_mismatch($sformatf("front_payload %h, want %h", rsp_tdata[54:23],
                                            want.front_tag));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_status.push_back(apply_request(req_tuser, req_tdata[15:0],
                                                    req_tdata[47:16]));
            accepted_requests <= accepted_requests + 1;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_percent()) begin
            stall_left <= $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int made;
      int run_len;
      int push_pct;
      int roll;
      kind_type kind;

      // empty queue corners, then fill with extremes and ties, overflow, drain a little
      add_request(KIND_PEEK, random_prio(), random_tag());
      add_request(KIND_POP, random_prio(), random_tag());
      add_request(KIND_SPARE, random_prio(), random_tag());
      add_request(KIND_PUSH, 16'sd32767, '0);
      add_request(KIND_PUSH, -16'sd32768, '1);
      add_request(KIND_PUSH, EMPTY_FRONT_PRIO, $urandom);
      add_request(KIND_PUSH, 16'sd0, $urandom);
      add_request(KIND_PUSH, -16'sd1, $urandom);
      add_request(KIND_PUSH, 16'sd5, 32'd1);
      add_request(KIND_PUSH, 16'sd5, 32'd2);
      add_request(KIND_PUSH, 16'sd5, 32'd3);
      for (int i = 0; i < DEPTH - 8; i++)
         add_request(KIND_PUSH, PRIO_BITS'($urandom_range(0, 20) - 10), $urandom);
      add_request(KIND_PUSH, 16'sd32767, $urandom);
      add_request(KIND_SPARE, random_prio(), random_tag());
      add_request(KIND_POP, random_prio(), random_tag());
      add_request(KIND_POP, random_prio(), random_tag());
      add_request(KIND_PEEK, random_prio(), random_tag());

      made = 0;
      while (made < RANDOM_REQUESTS) begin
         run_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
         endcase
         for (int i = 0; i < run_len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) kind = KIND_PUSH;
            else if (roll < push_pct + (100 - push_pct) * 3 / 4) kind = KIND_POP;
            else if ($urandom_range(0, 3) == 0) kind = KIND_SPARE;
            else kind = KIND_PEEK;
            add_request(kind, random_prio(), random_tag());
            made++;
         end
      end
      total_requests = pending_requests.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (checked_responses < total_requests)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
